### design/twds_pkg.sv
package twds_pkg;

  localparam int NODE_COUNT    = 4096;
  localparam int MAX_DEPTH     = 32;
  localparam int ALPHABET_SIZE = 27;

  localparam int NODE_W   = 12;
  localparam int LEN_W    = 6;
  localparam int KIND_W   = 3;
  localparam int SYM_W    = 5;
  localparam int CNT_W    = $clog2(NODE_COUNT + 1);
  localparam int CT_DEPTH = NODE_COUNT * ALPHABET_SIZE;
  localparam int CT_AW    = $clog2(CT_DEPTH);
  localparam int FLAG_AW  = $clog2(NODE_COUNT);
  localparam int STEP_W   = $clog2(MAX_DEPTH);

  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LZ   = 8'h7a;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UZ   = 8'h5a;
  localparam logic [SYM_W-1:0] SYM_APOS = SYM_W'(26);

  localparam logic [KIND_W-1:0] KIND_MATCH    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_STORED   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POOL     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_BAD_CHAR = 3'd3;
  localparam logic [KIND_W-1:0] KIND_TOO_LONG = 3'd4;
  localparam logic [KIND_W-1:0] KIND_NONE     = 3'd0;

  typedef struct packed {
    logic             is_scan;
    logic             is_sym;
    logic [SYM_W-1:0] sym;
    logic             word_end;
  } item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  match_length;
    logic [NODE_W-1:0] node_id;
    logic              last;
  } result_t;

  typedef struct packed {
    logic             clearing;
    logic [CNT_W-1:0] nodes_used;
  } stat_t;

  function automatic logic [CT_AW-1:0] ct_addr(input logic [NODE_W-1:0] node,
                                                input logic [SYM_W-1:0] sym);
    logic [CT_AW-1:0] prod;
    prod = CT_AW'(node) * CT_AW'(ALPHABET_SIZE);
    return prod + CT_AW'(sym);
  endfunction

  function automatic logic [SYM_W:0] classify(input logic [7:0] code);
    logic [7:0] ch;
    ch = code;
    if (ch >= CH_UA && ch <= CH_UZ) begin
      ch = ch - CH_UA + CH_LA;
    end
    if (ch >= CH_LA && ch <= CH_LZ) begin
      return {1'b1, SYM_W'(ch - CH_LA)};
    end
    if (ch == CH_APOS) begin
      return {1'b1, SYM_APOS};
    end
    return '0;
  endfunction

endpackage

### design/twds_if.sv
interface twds_in_if;
  import twds_pkg::*;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] char_code;
  logic       word_end;
  modport source(output valid, command, char_code, word_end, input ready);
  modport sink(input valid, command, char_code, word_end, output ready);
endinterface

interface twds_out_if;
  import twds_pkg::*;
  logic              valid;
  logic              ready;
  logic [KIND_W-1:0] kind;
  logic [LEN_W-1:0]  match_length;
  logic [NODE_W-1:0] node_id;
  logic              last;
  modport source(output valid, kind, match_length, node_id, last, input ready);
  modport sink(input valid, kind, match_length, node_id, last, output ready);
endinterface

### design/trie_dictionary_word_spotter_top.sv
// channel   dir  transaction payload
// in_ch     in   command, char_code, word_end
// out_ch    out  kind, match_length, node_id, last
//
// Insert character: one child-table read, a write for a new node. Scan letter:
// S_SCAN_RD, S_SCAN_WR per slot for all MAX_DEPTH candidate slots, through the
// single child-table read port. Token end: S_END_RD, S_END_CHK per slot, then
// S_FLUSH, plus output stalls. Reset clears the child table in one pass, with
// in_ch.ready low; a two-entry queue lets input run ahead of the back end.
module trie_dictionary_word_spotter_top (
  input  logic        clk,
  input  logic        rst_n,
  twds_in_if.sink     in_ch,
  twds_out_if.source  out_ch
);
  import twds_pkg::*;

  item_t push_item;
  item_t head;
  logic  push;
  logic  pop;
  logic  full;
  logic  empty;
  stat_t stat;

  twds_front u_front (
    .in_ch(in_ch), .clearing(stat.clearing), .fifo_full(full),
    .push(push), .item(push_item)
  );

  twds_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(push), .push_item(push_item), .pop(pop),
    .head(head), .full(full), .empty(empty)
  );

  twds_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .fifo_empty(empty), .pop(pop),
    .stat(stat), .out_ch(out_ch)
  );

`ifndef NO_ASSERTIONS
  a_no_accept_clear: assert property (@(posedge clk) disable iff (!rst_n)
    stat.clearing |-> !in_ch.ready) else $error("input taken during clear");
  a_pool_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.nodes_used <= CNT_W'(NODE_COUNT) && stat.nodes_used != '0)
    else $error("node pool count out of range");
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !full) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> !empty) else $error("queue underflow");
`endif
endmodule

### design/twds_ram.sv
module twds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### design/twds_front.sv
module twds_front (
  twds_in_if.sink          in_ch,
  input  logic             clearing,
  input  logic             fifo_full,
  output logic             push,
  output twds_pkg::item_t  item
);
  import twds_pkg::*;

  logic [SYM_W:0] cls;

  always_comb begin
    cls           = classify(in_ch.char_code);
    item.is_scan  = in_ch.command;
    item.is_sym   = cls[SYM_W];
    item.sym      = cls[SYM_W-1:0];
    item.word_end = in_ch.word_end;
    in_ch.ready   = !fifo_full && !clearing;
    push          = in_ch.valid && in_ch.ready;
  end
endmodule

### design/twds_fifo.sv
module twds_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  twds_pkg::item_t  push_item,
  input  logic             pop,
  output twds_pkg::item_t  head,
  output logic             full,
  output logic             empty
);
  import twds_pkg::*;

  item_t      slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign head  = slot_r[rd_ptr_r];
  assign full  = count_r == 2'd2;
  assign empty = count_r == 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) begin
        slot_r[wr_ptr_r] <= push_item;
        wr_ptr_r         <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
      count_r <= count_r + 2'(push) - 2'(pop);
    end
  end
endmodule

### design/twds_back.sv
module twds_back (
  input  logic             clk,
  input  logic             rst_n,
  input  twds_pkg::item_t  head,
  input  logic             fifo_empty,
  output logic             pop,
  output twds_pkg::stat_t  stat,
  twds_out_if.source       out_ch
);
  import twds_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_INS, S_INS_WR, S_INS_END,
    S_SCAN_RD, S_SCAN_WR, S_END_RD, S_END_CHK, S_FLUSH
  } state_t;

  state_t              state_r;
  logic [CT_AW-1:0]    clr_cnt_r;
  logic [CNT_W-1:0]    nodes_used_r;
  logic [NODE_W-1:0]   cursor_r;
  logic [LEN_W-1:0]    depth_r;
  logic [KIND_W-1:0]   reject_r;
  logic [NODE_W-1:0]   cand_r [MAX_DEPTH];
  logic [STEP_W-1:0]   step_r;
  logic [NODE_W-1:0]   prev_r;
  logic                pv_r;
  logic [NODE_W-1:0]   cur_r;
  logic [CT_AW-1:0]    addr_r;
  item_t               item_r;
  logic                pend_valid_r;
  logic [LEN_W-1:0]    pend_len_r;
  logic [NODE_W-1:0]   pend_node_r;
  logic                out_valid_r;
  result_t             out_r;

  logic                child_we;
  logic [CT_AW-1:0]    child_waddr;
  logic [NODE_W-1:0]   child_wdata;
  logic [CT_AW-1:0]    child_raddr;
  logic [NODE_W-1:0]   child_rdata;
  logic                flag_we;
  logic [FLAG_AW-1:0]  flag_waddr;
  logic                flag_wdata;
  logic [FLAG_AW-1:0]  flag_raddr;
  logic                flag_rdata;
  logic [NODE_W-1:0]   node_sel;
  logic                slot_free;
  logic                pool_full;
  logic                hit;
  logic                out_load;

  twds_ram #(.WIDTH(NODE_W), .DEPTH(CT_DEPTH)) u_child (
    .clk(clk), .we(child_we), .waddr(child_waddr), .wdata(child_wdata),
    .raddr(child_raddr), .rdata(child_rdata)
  );

  twds_ram #(.WIDTH(1), .DEPTH(NODE_COUNT)) u_flag (
    .clk(clk), .we(flag_we), .waddr(flag_waddr), .wdata(flag_wdata),
    .raddr(flag_raddr), .rdata(flag_rdata)
  );

  always_comb begin
    slot_free   = !out_valid_r || out_ch.ready;
    pool_full   = nodes_used_r == CNT_W'(NODE_COUNT);
    hit         = cur_r != '0 && flag_rdata;
    out_load    = slot_free &&
                  ((state_r == S_INS_END && item_r.word_end) ||
                   (state_r == S_END_CHK && hit && pend_valid_r) ||
                   (state_r == S_FLUSH && pend_valid_r));
    node_sel    = (state_r == S_INS) ? cursor_r : ((step_r == '0) ? '0 : prev_r);
    child_raddr = ct_addr(node_sel, item_r.sym);
    child_we    = (state_r == S_CLEAR) ||
                  (state_r == S_INS_WR && child_rdata == '0 && !pool_full);
    child_waddr = (state_r == S_CLEAR) ? clr_cnt_r : addr_r;
    child_wdata = (state_r == S_CLEAR) ? '0 : nodes_used_r[NODE_W-1:0];
    flag_we     = (state_r == S_CLEAR && clr_cnt_r < CT_AW'(NODE_COUNT)) ||
                  (state_r == S_INS_END && item_r.word_end && reject_r == KIND_NONE &&
                   slot_free);
    flag_waddr  = (state_r == S_CLEAR) ? clr_cnt_r[FLAG_AW-1:0] : FLAG_AW'(cursor_r);
    flag_wdata  = state_r != S_CLEAR;
    flag_raddr  = (state_r == S_END_CHK) ? FLAG_AW'(cur_r) : FLAG_AW'(cand_r[0]);
    pop         = state_r == S_IDLE && !fifo_empty;
    stat.clearing   = state_r == S_CLEAR;
    stat.nodes_used = nodes_used_r;

    out_ch.valid        = out_valid_r;
    out_ch.kind         = out_r.kind;
    out_ch.match_length = out_r.match_length;
    out_ch.node_id      = out_r.node_id;
    out_ch.last         = out_r.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_cnt_r    <= '0;
      nodes_used_r <= CNT_W'(1);
      cursor_r     <= '0;
      depth_r      <= '0;
      reject_r     <= KIND_NONE;
      step_r       <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
      for (int k = 0; k < MAX_DEPTH; k++) begin
        cand_r[k] <= '0;
      end
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        S_CLEAR: begin
          clr_cnt_r <= clr_cnt_r + 1'b1;
          if (clr_cnt_r == CT_AW'(CT_DEPTH - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!fifo_empty) begin
            item_r <= head;
            step_r <= '0;
            prev_r <= '0;
            if (!head.is_scan) begin
              state_r <= S_INS;
            end else if (head.is_sym) begin
              state_r <= S_SCAN_RD;
            end else begin
              state_r <= S_END_RD;
            end
          end
        end
        S_INS: begin
          addr_r <= child_raddr;
          if (reject_r != KIND_NONE) begin
            state_r <= S_INS_END;
          end else if (!item_r.is_sym) begin
            reject_r <= KIND_BAD_CHAR;
            state_r  <= S_INS_END;
          end else if (depth_r >= LEN_W'(MAX_DEPTH)) begin
            reject_r <= KIND_TOO_LONG;
            state_r  <= S_INS_END;
          end else begin
            state_r <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          if (child_rdata != '0) begin
            cursor_r <= child_rdata;
            depth_r  <= depth_r + 1'b1;
          end else if (pool_full) begin
            reject_r <= KIND_POOL;
          end else begin
            cursor_r     <= nodes_used_r[NODE_W-1:0];
            nodes_used_r <= nodes_used_r + 1'b1;
            depth_r      <= depth_r + 1'b1;
          end
          state_r <= S_INS_END;
        end
        S_INS_END: begin
          if (!item_r.word_end) begin
            state_r <= S_IDLE;
          end else if (slot_free) begin
            out_r.last  <= 1'b1;
            if (reject_r == KIND_NONE) begin
              out_r.kind         <= KIND_STORED;
              out_r.match_length <= depth_r;
              out_r.node_id      <= cursor_r;
            end else begin
              out_r.kind         <= reject_r;
              out_r.match_length <= '0;
              out_r.node_id      <= '0;
            end
            cursor_r <= '0;
            depth_r  <= '0;
            reject_r <= KIND_NONE;
            state_r  <= S_IDLE;
          end
        end
        S_SCAN_RD: begin
          pv_r    <= (step_r == '0) || (prev_r != '0);
          state_r <= S_SCAN_WR;
        end
        S_SCAN_WR: begin
          for (int k = 0; k < MAX_DEPTH - 1; k++) begin
            cand_r[k] <= cand_r[k+1];
          end
          cand_r[MAX_DEPTH-1] <= pv_r ? child_rdata : '0;
          prev_r <= cand_r[0];
          step_r <= step_r + 1'b1;
          state_r <= (step_r == STEP_W'(MAX_DEPTH - 1)) ? S_IDLE : S_SCAN_RD;
        end
        S_END_RD: begin
          cur_r   <= cand_r[0];
          state_r <= S_END_CHK;
        end
        S_END_CHK: begin
          if (!(hit && pend_valid_r && !slot_free)) begin
            if (hit) begin
              if (pend_valid_r) begin
                out_r.kind         <= KIND_MATCH;
                out_r.match_length <= pend_len_r;
                out_r.node_id      <= pend_node_r;
                out_r.last         <= 1'b0;
              end
              pend_valid_r <= 1'b1;
              pend_len_r   <= LEN_W'(step_r) + 1'b1;
              pend_node_r  <= cur_r;
            end
            for (int k = 0; k < MAX_DEPTH - 1; k++) begin
              cand_r[k] <= cand_r[k+1];
            end
            cand_r[MAX_DEPTH-1] <= '0;
            step_r <= step_r + 1'b1;
            state_r <= (step_r == STEP_W'(MAX_DEPTH - 1)) ? S_FLUSH : S_END_RD;
          end
        end
        S_FLUSH: begin
          if (!pend_valid_r) begin
            state_r <= S_IDLE;
          end else if (slot_free) begin
            out_r.kind         <= KIND_MATCH;
            out_r.match_length <= pend_len_r;
            out_r.node_id      <= pend_node_r;
            out_r.last         <= 1'b1;
            pend_valid_r       <= 1'b0;
            state_r            <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
